// File: rtl/core/chs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants for the chained hash set block.
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam int MAX_BUCKETS_DEF = 64;
    localparam int WAYS_DEF        = 4;

    localparam int KEY_W     = 32;
    localparam int CNT_W     = 7;
    localparam int IDX_OUT_W = 6;
    localparam int OUT_W     = 8;

    localparam logic [CNT_W-1:0] CNT_RESET = 7'd10;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // Table port strobes issued by the sequencer
    typedef struct packed {
        logic fill_rd;
        logic fill_wr;
        logic slot_rd;
        logic slot_wr;
    } tbl_ctrl_t;

endpackage

// File: rtl/core/chs_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_divider
// Bit-serial restoring remainder of a 32-bit key by a 7-bit bucket count.
// ----------------------------------------------------------------------------
module chs_divider
    import chs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [CNT_W-1:0] remainder
);

    localparam int STEP_W = $clog2(KEY_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [KEY_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic [CNT_W-1:0]  rem_next;

    // One quotient bit per cycle: shift in, subtract when it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[KEY_W-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = diff[CNT_W-1:0];
        end
        else
        begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(KEY_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[KEY_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/chs_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_table
// Slot key memory and per-bucket fill count memory, registered reads.
// ----------------------------------------------------------------------------
module chs_table
    import chs_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int WAYS        = WAYS_DEF,
    localparam int BIDX_W     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int FILL_W     = $clog2(WAYS + 1)
)
(
    input  logic                  clk,
    input  tbl_ctrl_t             ctrl,
    input  logic [BIDX_W-1:0]     bucket,
    input  logic [WAY_W-1:0]      way,
    input  logic [FILL_W-1:0]     fill_wdata,
    input  logic [KEY_W-1:0]      key_wdata,
    output logic [FILL_W-1:0]     fill_rdata,
    output logic [KEY_W-1:0]      slot_rdata
);

    localparam int SLOTS   = MAX_BUCKETS * WAYS;
    localparam int SADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [KEY_W-1:0]  slot_mem [SLOTS];
    logic [FILL_W-1:0] fill_mem [MAX_BUCKETS];
    logic [SADDR_W-1:0] slot_addr;
    logic [KEY_W-1:0]  slot_rdata_reg;
    logic [FILL_W-1:0] fill_rdata_reg;

    assign slot_addr = SADDR_W'(int'(bucket) * WAYS + int'(way));

    always_ff @(posedge clk)
    begin
        if (ctrl.slot_wr)
        begin
            slot_mem[slot_addr] <= key_wdata;
        end
        if (ctrl.slot_rd)
        begin
            slot_rdata_reg <= slot_mem[slot_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fill_wr)
        begin
            fill_mem[bucket] <= fill_wdata;
        end
        if (ctrl.fill_rd)
        begin
            fill_rdata_reg <= fill_mem[bucket];
        end
    end

    assign slot_rdata = slot_rdata_reg;
    assign fill_rdata = fill_rdata_reg;

endmodule

// File: rtl/core/chained_hash_set_insert_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_set_insert_lookup
// Hash set of 32-bit keys in buckets of WAYS slots, with lookup and insert.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the operation (lookup or insert), tdata the
//   key. Each request yields exactly one result transfer on the output
//   stream: answer, bucket_full and the bucket index.
//   The bucket is key modulo bucket_count (zero reads as one, values above
//   MAX_BUCKETS saturate). The user must write bucket_count on the config
//   channel only while no request is in flight; the block does not enforce
//   this. Stored keys are never rehashed. A request passes the bit-serial
//   remainder unit, a fill count read, then a scan of the bucket's filled
//   slots (up to WAYS) in the one-port slot memory, one slot at a time,
//   stopping at a hit; on a miss the insert decision follows.
//   Flow: one request in flight; tready is low while it is worked on and
//   the next transfer can come in the same cycle as output valid rises.
//   Reset: after rst_n rises, the fill counts are cleared one bucket per
//   cycle, all MAX_BUCKETS of them, before the first request is taken.
//   Output stall: the result is held in an output register; a finished
//   request waits until that register is free, and the input stays blocked.
// ----------------------------------------------------------------------------
module chained_hash_set_insert_lookup
    import chs_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int WAYS        = WAYS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [KEY_W-1:0] s_axis_tdata,  // [31:0] key
    input  logic             s_axis_tuser,  // [0] func
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,  // [0] answer, [1] bucket_full,
                                            // [7:2] bucket_index
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int BIDX_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W  = $clog2(WAYS + 1);
    localparam int MB_W    = $clog2(MAX_BUCKETS + 1);
    localparam int CMP_W   = (MB_W > CNT_W) ? MB_W : CNT_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_FILL_RD,
        ST_FILL_WAIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [BIDX_W-1:0] clr_reg, clr_next;
    logic              func_reg, func_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] way_reg, way_next;
    logic              ans_reg, ans_next;
    logic              full_reg, full_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    logic [CNT_W-1:0]  eff_count;
    logic              div_start;
    logic              div_done;
    logic [CNT_W-1:0]  div_rem;
    tbl_ctrl_t         tbl_ctrl;
    logic [BIDX_W-1:0] tbl_bucket;
    logic [FILL_W-1:0] fill_wdata;
    logic [FILL_W-1:0] fill_rdata;
    logic [KEY_W-1:0]  slot_rdata;
    logic              key_match;
    logic              in_xfer;

    // Scan reads the current way; the insert writes the first free way
    function automatic logic [WAY_W-1:0] tbl_way_sel(
        input state_t            st,
        input logic [FILL_W-1:0] way,
        input logic [FILL_W-1:0] fill
    );
        logic [WAY_W-1:0] sel;
        sel = WAY_W'(way);
        if (st == ST_DECIDE)
        begin
            sel = WAY_W'(fill);
        end
        return sel;
    endfunction

    // Effective bucket count: zero reads as one, saturate at MAX_BUCKETS
    always_comb
    begin
        eff_count = cnt_reg;
        if (cnt_reg == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (CMP_W'(cnt_reg) > CMP_W'(MAX_BUCKETS))
        begin
            eff_count = CNT_W'(MAX_BUCKETS);
        end
    end

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign div_start = in_xfer;
    assign key_match = (slot_rdata == key_reg);

    chs_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (s_axis_tdata),
        .divisor   (eff_count),
        .done      (div_done),
        .remainder (div_rem)
    );

    chs_table #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .WAYS        (WAYS)
    ) u_table (
        .clk        (clk),
        .ctrl       (tbl_ctrl),
        .bucket     (tbl_bucket),
        .way        (tbl_way_sel(state_reg, way_reg, fill_reg)),
        .fill_wdata (fill_wdata),
        .key_wdata  (key_reg),
        .fill_rdata (fill_rdata),
        .slot_rdata (slot_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        rem_next       = rem_reg;
        fill_next      = fill_reg;
        way_next       = way_reg;
        ans_next       = ans_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        tbl_ctrl       = '0;
        tbl_bucket     = BIDX_W'(rem_reg);
        fill_wdata     = '0;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                tbl_ctrl.fill_wr = 1'b1;
                tbl_bucket       = clr_reg;
                clr_next         = clr_reg + 1'b1;
                if (clr_reg == BIDX_W'(MAX_BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    func_next  = s_axis_tuser;
                    key_next   = s_axis_tdata;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    rem_next   = div_rem;
                    state_next = ST_FILL_RD;
                end
            end
            ST_FILL_RD:
            begin
                tbl_ctrl.fill_rd = 1'b1;
                state_next       = ST_FILL_WAIT;
            end
            ST_FILL_WAIT:
            begin
                fill_next  = fill_rdata;
                way_next   = '0;
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                if (way_reg == fill_reg)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    tbl_ctrl.slot_rd = 1'b1;
                    state_next       = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if (key_match)
                begin
                    // Present: lookup hits, insert of a duplicate answers 0
                    ans_next   = (func_reg == FUNC_LOOKUP);
                    full_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    way_next   = way_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_DECIDE:
            begin
                ans_next  = 1'b0;
                full_next = 1'b0;
                if (func_reg == FUNC_INSERT)
                begin
                    if (fill_reg >= FILL_W'(WAYS))
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        tbl_ctrl.slot_wr = 1'b1;
                        tbl_ctrl.fill_wr = 1'b1;
                        fill_wdata       = fill_reg + 1'b1;
                        ans_next         = 1'b1;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {rem_reg[IDX_OUT_W-1:0], full_reg, ans_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= CNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cnt_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        key_reg      <= key_next;
        rem_reg      <= rem_next;
        fill_reg     <= fill_next;
        way_reg      <= way_next;
        ans_reg      <= ans_next;
        full_reg     <= full_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

endmodule

// File: rtl/core/chs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks for the chained hash set, bound to the top level.
// ----------------------------------------------------------------------------
module chs_checker
    import chs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // One request at a time: input blocks right after a transfer
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // A result cannot appear in the cycle after the request that caused it
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(in_xfer))
        else $error("result raised directly after input transfer");

    // A refused insert never reports success
    a_full_not_answer: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("answer and bucket_full both set");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind chained_hash_set_insert_lookup chs_checker u_chs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
